/* hdl/rnt_pkg.sv */
// ----------------------------------------------------------------------------
// rnt_pkg
// shared types, constants and the digit glyph function of the number printer
// ----------------------------------------------------------------------------
`default_nettype none

package rnt_pkg;

  localparam int unsigned ValueW     = 64;
  localparam int unsigned RadixW     = 6;
  localparam int unsigned WidthW     = 7;
  localparam int unsigned CharW      = 8;
  localparam int unsigned DigitW     = 6;
  localparam int unsigned RemW       = 7;   // one bit above the radix for the trial subtract
  localparam int unsigned BitsPerCyc = 4;   // quotient bits retired per divider cycle
  localparam int unsigned DivCycles  = ValueW / BitsPerCyc;
  localparam int unsigned DivCntW    = $clog2(DivCycles);

  localparam logic [RadixW-1:0] RadixMin = 6'd2;
  localparam logic [RadixW-1:0] RadixMax = 6'd36;
  localparam logic [WidthW-1:0] WidthCap = 7'd64;
  localparam logic [DigitW-1:0] DigitTop = 6'd35;

  // divider control from the sequencer
  typedef struct packed {
    logic load;   // take a new dividend and radix, then divide
    logic go;     // divide the held quotient again
  } div_req_t;

  // divider result back to the sequencer
  typedef struct packed {
    logic              done;
    logic              zero;   // quotient is zero
    logic [DigitW-1:0] rem;
  } div_rsp_t;

  // digit to lowercase ascii, out-of-range digits clamp to 'z'
  function automatic logic [CharW-1:0] glyph(input logic [DigitW-1:0] d);
    logic [DigitW-1:0] dc;
    dc = (d > DigitTop) ? DigitTop : d;
    if (dc < 6'd10) begin
      return 8'h30 + {2'b00, dc};
    end
    return 8'h61 + {2'b00, dc} - 8'd10;
  endfunction

endpackage

`default_nettype wire

/* hdl/radix_number_to_text.sv */
// ----------------------------------------------------------------------------
// radix_number_to_text
// prints an unsigned 64-bit number as padded ascii text in radix 2 to 36
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                      transfer
//  s_axis    in   value, radix, min_width, pad_char            one number
//  m_axis    out  char_out, tlast = last character             one character
//
//  the divider finds each digit at 4 quotient bits per cycle; pad characters go
//  out one per cycle while m_axis does not stall, and each digit then passes
//  through the digit memory read port in the read state and the load state
//  a new number is taken once the last character sits in the output register
//  reset clears the sequencer and output valid; the digit memory needs none
//  a stalled m_axis holds the sequencer in its pad and load states, never the taken character
//
`default_nettype none

module radix_number_to_text #(
  parameter int unsigned MAX_DIGITS = 64
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // [63:0] value, [69:64] radix, [76:70] min_width, [84:77] pad_char, [87:85] zero
  input  wire  [87:0]                        s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // [7:0] char_out
  output logic [7:0]                         m_axis_tdata,
  // last
  output logic                               m_axis_tlast
);

  localparam int unsigned IdxW = $clog2(MAX_DIGITS);
  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,    // waiting for a digit from the divider
    S_PAD,    // emitting pad characters
    S_RD,     // digit memory read issued
    S_LD      // digit read back, loading the output register
  } state_e;

  // input fields
  logic [rnt_pkg::ValueW-1:0] in_value;
  logic [rnt_pkg::RadixW-1:0] in_radix;
  logic [rnt_pkg::WidthW-1:0] in_width;
  logic [rnt_pkg::CharW-1:0]  in_pad;

  assign in_value = s_axis_tdata[63:0];
  assign in_radix = s_axis_tdata[69:64];
  assign in_width = s_axis_tdata[76:70];
  assign in_pad   = s_axis_tdata[84:77];

  state_e                     state_q;
  logic [CntW-1:0]            n_q;       // digit count of the latest number
  logic [IdxW-1:0]            idx_q;     // digit being read out
  logic [rnt_pkg::WidthW-1:0] width_q;
  logic [rnt_pkg::WidthW-1:0] pad_cnt_q;
  logic [rnt_pkg::CharW-1:0]  pad_q;
  logic                       out_valid_q;
  logic [rnt_pkg::CharW-1:0]  out_char_q;
  logic                       out_last_q;

  rnt_pkg::div_req_t          div_req;
  rnt_pkg::div_rsp_t          div_rsp;
  logic                       mem_we, mem_re;
  logic [rnt_pkg::DigitW-1:0] mem_rdata;

  logic                       in_xfer, radix_ok, slot_free, out_load;
  logic [CntW-1:0]            n_next;
  logic                       div_last;
  logic [rnt_pkg::WidthW-1:0] n_next_w, pads;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign radix_ok      = (in_radix inside {[rnt_pkg::RadixMin:rnt_pkg::RadixMax]});
  // the output register can take a character this cycle
  assign slot_free     = !out_valid_q || m_axis_tready;
  // a pad or a digit goes into the output register this cycle
  assign out_load      = slot_free && ((state_q == S_PAD) || (state_q == S_LD));

  // digit bookkeeping on each divider result; stop at the store depth,
  // keeping only the least significant digits
  assign n_next   = n_q + 1'b1;
  assign div_last = div_rsp.zero || (n_next == CntW'(MAX_DIGITS));
  assign n_next_w = rnt_pkg::WidthW'(n_next);
  assign pads     = (width_q > n_next_w) ? (width_q - n_next_w) : '0;

  always_comb begin
    div_req.load = in_xfer && radix_ok;
    div_req.go   = (state_q == S_DIV) && div_rsp.done && !div_last;
  end

  // writes happen only while dividing, reads only after; no overlap to forward
  assign mem_we = (state_q == S_DIV) && div_rsp.done;
  assign mem_re = (state_q == S_RD);

  rnt_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (div_req),
    .value_i (in_value),
    .radix_i (in_radix),
    .rsp_o   (div_rsp)
  );

  rnt_digit_mem #(
    .Depth (MAX_DIGITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (n_q[IdxW-1:0]),
    .wdata_i (div_rsp.rem),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      idx_q       <= '0;
      pad_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          // a radix out of range is dropped with no characters
          if (in_xfer && radix_ok) begin
            n_q     <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            n_q <= n_next;
            if (div_last) begin
              idx_q     <= IdxW'(n_q);
              pad_cnt_q <= pads;
              state_q   <= (pads != '0) ? S_PAD : S_RD;
            end
          end
        end
        S_PAD: begin
          if (slot_free) begin
            out_char_q  <= pad_q;
            out_last_q  <= 1'b0;
            pad_cnt_q   <= pad_cnt_q - 1'b1;
            if (pad_cnt_q == rnt_pkg::WidthW'(1)) begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: begin
          state_q <= S_LD;
        end
        S_LD: begin
          if (slot_free) begin
            out_char_q  <= rnt_pkg::glyph(mem_rdata);
            out_last_q  <= (idx_q == '0);
            if (idx_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q - 1'b1;
              state_q <= S_RD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // per-number settings, captured with the number
  always_ff @(posedge clk_i) begin
    if (in_xfer && radix_ok) begin
      width_q <= (in_width > rnt_pkg::WidthCap) ? rnt_pkg::WidthCap : in_width;
      pad_q   <= in_pad;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

  // divider results only arrive while the sequencer waits for them
  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider result outside the divide phase");

  // a digit write never runs past the store
  a_write_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (n_q < CntW'(MAX_DIGITS)))
    else $error("digit write beyond the store depth");

  // the pad phase always has a character left to send
  a_pad_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PAD) |-> (pad_cnt_q != '0))
    else $error("pad phase with no pad left");

  // a read issued is followed by its load phase
  a_read_then_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |=> (state_q == S_LD))
    else $error("digit read not followed by load");

endmodule

`default_nettype wire

/* hdl/rnt_divider.sv */
// ----------------------------------------------------------------------------
// rnt_divider
// iterative restoring divider, 64-bit dividend by a 6-bit radix
// ----------------------------------------------------------------------------
`default_nettype none

module rnt_divider (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  rnt_pkg::div_req_t                  req_i,
  input  wire  [rnt_pkg::ValueW-1:0]         value_i,
  input  wire  [rnt_pkg::RadixW-1:0]         radix_i,
  output rnt_pkg::div_rsp_t                  rsp_o
);

  logic [rnt_pkg::ValueW-1:0]  x_q, x_d;
  logic [rnt_pkg::RemW-1:0]    r_q, r_d;
  logic [rnt_pkg::RadixW-1:0]  radix_q;
  logic [rnt_pkg::DivCntW-1:0] cnt_q;
  logic                        busy_q, done_q;

  // BitsPerCyc quotient bits per cycle, quotient shifts in where the dividend leaves
  always_comb begin
    logic [rnt_pkg::ValueW-1:0] x;
    logic [rnt_pkg::RemW-1:0]   r;
    logic                       qb;
    x = x_q;
    r = r_q;
    for (int s = 0; s < int'(rnt_pkg::BitsPerCyc); s++) begin
      r  = {r[rnt_pkg::RemW-2:0], x[rnt_pkg::ValueW-1]};
      qb = (r >= {1'b0, radix_q});
      if (qb) begin
        r = r - {1'b0, radix_q};
      end
      x = {x[rnt_pkg::ValueW-2:0], qb};
    end
    x_d = x;
    r_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.load || req_i.go) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == rnt_pkg::DivCntW'(rnt_pkg::DivCycles - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      x_q     <= value_i;
      radix_q <= radix_i;
      r_q     <= '0;
    end else if (req_i.go) begin
      r_q <= '0;
    end else if (busy_q) begin
      x_q <= x_d;
      r_q <= r_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.zero = (x_q == '0);
  assign rsp_o.rem  = r_q[rnt_pkg::DigitW-1:0];

endmodule

`default_nettype wire

/* hdl/rnt_digit_mem.sv */
// ----------------------------------------------------------------------------
// rnt_digit_mem
// digit store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rnt_digit_mem #(
  parameter int unsigned Depth = 64
) (
  input  wire                              clk_i,
  input  wire                              we_i,
  input  wire  [$clog2(Depth)-1:0]         waddr_i,
  input  wire  [rnt_pkg::DigitW-1:0]       wdata_i,
  input  wire                              re_i,
  input  wire  [$clog2(Depth)-1:0]         raddr_i,
  output logic [rnt_pkg::DigitW-1:0]       rdata_o
);

  logic [rnt_pkg::DigitW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the radix number printer: numbers go in on s_axis,
// the expected padded text is worked out per accepted number and compared
// character by character with what comes out on m_axis
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned LimitCycles  = 5_000_000;
  localparam int unsigned TailCycles   = 1500;  // longer than one 64-digit number
  localparam int unsigned HoldMark     = 60;    // numbers issued before the long stall
  localparam int unsigned HoldCycles   = 600;
  localparam int unsigned RandomCount  = 440;
  localparam int unsigned DigitSlots   = 64;

  typedef struct {
    logic [rnt_pkg::ValueW-1:0] value;
    logic [rnt_pkg::RadixW-1:0] radix;
    logic [rnt_pkg::WidthW-1:0] min_width;
    logic [rnt_pkg::CharW-1:0]  pad;
    bit                         drain_first;  // hold this number back until all text is out
  } number_req_t;

  typedef struct {
    logic [rnt_pkg::CharW-1:0] ch;
    logic                      last;
  } text_char_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  wire          s_axis_tready;
  logic [87:0]  s_axis_tdata;
  wire          m_axis_tvalid;
  logic         m_axis_tready;
  wire  [7:0]   m_axis_tdata;
  wire          m_axis_tlast;

  number_req_t  pending_numbers[$];
  text_char_t   expected_text[$];
  number_req_t  offered;
  bit           offering;
  bit           number_taken;
  int unsigned  items_issued;
  int unsigned  numbers_taken;
  int unsigned  total_numbers;
  int unsigned  idle_phase;
  int unsigned  hold_left;
  bit           hold_done;
  int unsigned  mismatches;
  int unsigned  cycles;

  radix_number_to_text i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // expected text of one number: leading pads, then digits most significant first
  function automatic void spell_number(input number_req_t req);
    logic [rnt_pkg::ValueW-1:0] rest;
    logic [rnt_pkg::DigitW-1:0] digits[DigitSlots];
    int unsigned                count;
    int unsigned                width;
    text_char_t                 tc;
    // a radix outside 2..36 prints nothing
    if (req.radix < rnt_pkg::RadixMin || req.radix > rnt_pkg::RadixMax) begin
      return;
    end
    width = (req.min_width > rnt_pkg::WidthCap) ? rnt_pkg::WidthCap : req.min_width;
    rest  = req.value;
    count = 0;
    // repeated division, least significant digit first; zero still gives one digit
    do begin
      if (count < DigitSlots) begin
        digits[count] = rnt_pkg::DigitW'(rest % req.radix);
        count++;
      end
      rest = rest / req.radix;
    end while (rest != 0);
    for (int unsigned i = count; i < width; i++) begin
      tc.ch   = req.pad;
      tc.last = 1'b0;
      expected_text.push_back(tc);
    end
    for (int i = count - 1; i >= 0; i--) begin
      // 0-9 from 0x30, then lowercase letters from 0x61
      tc.ch   = (digits[i] < 10) ? rnt_pkg::CharW'(8'h30 + digits[i])
                                 : rnt_pkg::CharW'(8'h61 + digits[i] - 10);
      tc.last = (i == 0);
      expected_text.push_back(tc);
    end
  endfunction

  task automatic queue_number(input logic [rnt_pkg::ValueW-1:0] value,
                              input logic [rnt_pkg::RadixW-1:0] radix,
                              input logic [rnt_pkg::WidthW-1:0] min_width,
                              input logic [rnt_pkg::CharW-1:0]  pad,
                              input bit drain_first);
    number_req_t req;
    req.value       = value;
    req.radix       = radix;
    req.min_width   = min_width;
    req.pad         = pad;
    req.drain_first = drain_first;
    pending_numbers.push_back(req);
  endtask

  // random number: mostly valid radix and modest widths, lengths spread over all sizes
  task automatic queue_random_number(input bit drain_first);
    logic [rnt_pkg::ValueW-1:0] value;
    logic [rnt_pkg::RadixW-1:0] radix;
    logic [rnt_pkg::WidthW-1:0] min_width;
    logic [rnt_pkg::CharW-1:0]  pad;
    int unsigned                pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      value = '0;
    end else if (pick < 8) begin
      value = '1;
    end else if (pick < 20) begin
      value = {$urandom, $urandom};
    end else begin
      value = {$urandom, $urandom} >> $urandom_range(0, rnt_pkg::ValueW - 1);
    end
    radix = ($urandom_range(0, 99) < 90) ? rnt_pkg::RadixW'($urandom_range(2, 36))
                                          : rnt_pkg::RadixW'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      min_width = rnt_pkg::WidthW'($urandom_range(0, 20));
    end else if (pick < 94) begin
      min_width = rnt_pkg::WidthW'($urandom_range(0, 64));
    end else begin
      min_width = rnt_pkg::WidthW'($urandom_range(65, 127));
    end
    pick = $urandom_range(0, 3);
    pad  = (pick == 0) ? 8'h20 : (pick == 1) ? 8'h30
                               : rnt_pkg::CharW'($urandom_range(0, 255));
    queue_number(value, radix, min_width, pad, drain_first);
  endtask

  // driver: a number stays offered until the block takes it
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (number_taken) begin
        number_taken = 1'b0;
        offering     = 1'b0;
      end
      if (!offering && pending_numbers.size() != 0 &&
          $urandom_range(0, 99) >= ((idle_phase == 0) ? 26 : (idle_phase == 1) ? 48 : 0) &&
          (!pending_numbers[0].drain_first || expected_text.size() == 0)) begin
        offered  = pending_numbers.pop_front();
        offering = 1'b1;
        items_issued++;
      end
      s_axis_tvalid <= offering;
      s_axis_tdata  <= {3'b000, offered.pad, offered.min_width, offered.radix, offered.value};
    end
  end

  // receiver ready, low for the whole long stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= (hold_left == 0) &&
                       ($urandom_range(0, 99) >=
                        ((idle_phase == 0) ? 48 : (idle_phase == 1) ? 26 : 0));
    end
  end

  // long receiver stall once the run is under way, so the block backs up into s_axis
  always @(posedge clk_i) begin
    if (!hold_done && items_issued >= HoldMark) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end else if (hold_left != 0) begin
      hold_left--;
    end
  end

  // monitor: predict on each accepted number, check each character transfer
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        spell_number(offered);
        number_taken = 1'b1;
        numbers_taken++;
        idle_phase = (numbers_taken * 3 >= total_numbers * 2) ? 2 :
                     (numbers_taken * 3 >= total_numbers) ? 1 : 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_text.size() == 0) begin
          $error("char_out: expected nothing, got %h (last %b)", m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_text.pop_front();
          if (m_axis_tdata !== want.ch) begin
            $error("char_out: expected %h, got %h", want.ch, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %b, got %b", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LimitCycles) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    offered       = '{default: '0};

    // directed: zero, full-length numbers, radix extremes, widths, pads
    queue_number(64'd0, 6'd10, 7'd0, 8'h20, 1'b0);
    queue_number(64'd0, 6'd2, 7'd5, 8'h30, 1'b0);
    queue_number('1, 6'd2, 7'd0, 8'h20, 1'b0);                 // 64 binary digits
    queue_number('1, 6'd10, 7'd0, 8'h20, 1'b0);
    queue_number('1, 6'd16, 7'd64, 8'h2a, 1'b0);              // width at the cap
    queue_number('1, 6'd36, 7'd0, 8'h20, 1'b0);
    queue_number(64'd35, 6'd36, 7'd0, 8'h20, 1'b0);           // highest glyph
    queue_number(64'd36, 6'd36, 7'd0, 8'h20, 1'b0);
    queue_number(64'd1234567890, 6'd10, 7'd10, 8'h20, 1'b0);  // width equals digit count
    queue_number(64'd255, 6'd16, 7'd127, 8'h00, 1'b0);        // width saturates
    queue_number(64'd7, 6'd8, 7'd65, 8'hff, 1'b0);
    queue_number(64'd5, 6'd0, 7'd4, 8'h20, 1'b0);             // radix out of range
    queue_number(64'd5, 6'd1, 7'd4, 8'h20, 1'b0);
    queue_number(64'd5, 6'd37, 7'd4, 8'h20, 1'b0);
    queue_number('1, 6'd63, 7'd127, 8'hff, 1'b0);
    queue_number(64'h8000_0000_0000_0000, 6'd2, 7'd64, 8'h30, 1'b0);
    queue_number(64'hdead_beef_0bad_cafe, 6'd3, 7'd3, 8'h20, 1'b0);
    queue_number(64'd12345, 6'd7, 7'd8, 8'h78, 1'b1);         // sender waits for drain
    queue_number(64'd1, 6'd2, 7'd1, 8'h20, 1'b0);

    for (int i = 0; i < RandomCount; i++) begin
      queue_random_number(i == 0 || i == RandomCount / 2 || $urandom_range(0, 99) < 2);
    end
    total_numbers = pending_numbers.size();

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // all numbers taken and all text received
    while (pending_numbers.size() != 0 || offering || expected_text.size() != 0) begin
      @(posedge clk_i);
    end
    // catch stray characters from the last number
    repeat (TailCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
